FILE: rtl/prur_pkg.sv
`default_nettype none
package prur_pkg;

  localparam int unsigned ELEMENTS_DEF = 8;
  localparam int unsigned POS_BITS     = 4;
  localparam int unsigned PERM_W       = 32;
  localparam int unsigned RANK_W       = 16;
  localparam int unsigned POS_SLOTS    = PERM_W / POS_BITS;

  // handshake and item kind travel together down the chain
  typedef struct packed {
    logic valid;
    logic mode;
  } prur_ctl_t;

  function automatic logic [63:0] fact(input int unsigned n);
    logic [63:0] f;
    f = 64'd1;
    for (int unsigned k = 2; k <= n; k++) begin
      f = f * 64'(k);
    end
    return f;
  endfunction

  // positions above the packed field read as zero
  function automatic logic [POS_BITS-1:0] get_pos(input logic [PERM_W-1:0] p,
                                                  input int unsigned i);
    logic [POS_BITS-1:0] v;
    v = '0;
    if (i < POS_SLOTS) begin
      v = p[i*POS_BITS +: POS_BITS];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/prur_front.sv
`default_nettype none
module prur_front #(
  parameter int unsigned ELEMENTS = prur_pkg::ELEMENTS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  prur_pkg::prur_ctl_t          up_ctl,
  output logic                         up_ready,
  input  wire [prur_pkg::PERM_W-1:0]   up_perm,
  input  wire [prur_pkg::RANK_W-1:0]   up_coord,
  output prur_pkg::prur_ctl_t          dn_ctl,
  input  wire                          dn_ready,
  output logic [prur_pkg::PERM_W-1:0]  dn_perm,
  output logic [prur_pkg::RANK_W-1:0]  dn_rem
);
  import prur_pkg::*;

  // coordinate mod ELEMENTS!: reciprocal multiply, then subtract one multiple
  localparam logic [63:0] NFACT    = fact(ELEMENTS);
  localparam bit          BIG      = NFACT > 64'd65535;
  localparam int unsigned SH       = RANK_W + $clog2(NFACT);
  localparam logic [63:0] MAG_FULL = ((64'd1 << SH) + NFACT - 64'd1) / NFACT;
  localparam logic [RANK_W:0] MAG  = MAG_FULL[RANK_W:0];

  logic                vld_a;
  logic                mode_a;
  logic [PERM_W-1:0]   perm_a;
  logic [RANK_W-1:0]   coord_a;
  logic [RANK_W-1:0]   q_a;
  logic                ready_a;

  logic                vld_b;
  logic                mode_b;
  logic [PERM_W-1:0]   perm_b;
  logic [RANK_W-1:0]   rem_b;
  logic                ready_b;

  logic [2*RANK_W:0]   prod;
  logic [RANK_W-1:0]   q_next;
  logic [RANK_W-1:0]   rem_next;

  assign ready_b  = !vld_b || dn_ready;
  assign ready_a  = !vld_a || ready_b;
  assign up_ready = ready_a;

  always_comb begin
    prod = (2*RANK_W+1)'(up_coord) * (2*RANK_W+1)'(MAG);
    if (BIG) begin
      q_next = '0;
    end else begin
      q_next = RANK_W'(prod >> SH);
    end
    rem_next = coord_a - RANK_W'(64'(q_a) * NFACT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
    end else begin
      if (ready_a) begin
        vld_a <= up_ctl.valid;
      end
      if (ready_b) begin
        vld_b <= vld_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      mode_a  <= up_ctl.mode;
      perm_a  <= up_perm;
      coord_a <= up_coord;
      q_a     <= q_next;
    end
    if (ready_b) begin
      mode_b <= mode_a;
      perm_b <= perm_a;
      rem_b  <= rem_next;
    end
  end

  assign dn_ctl.valid = vld_b;
  assign dn_ctl.mode  = mode_b;
  assign dn_perm      = perm_b;
  assign dn_rem       = rem_b;

  a_q_low : assert property (@(posedge clk) disable iff (rst)
    vld_a |-> 64'(q_a) * NFACT <= 64'(coord_a))
    else $error("front quotient too large");

  a_q_high : assert property (@(posedge clk) disable iff (rst)
    vld_a |-> 64'(coord_a) < (64'(q_a) + 64'd1) * NFACT)
    else $error("front quotient too small");

  a_rem_range : assert property (@(posedge clk) disable iff (rst)
    vld_b |-> 64'(rem_b) < NFACT)
    else $error("front remainder out of range");

endmodule
`default_nettype wire

FILE: rtl/prur_cell.sv
`default_nettype none
module prur_cell #(
  parameter int unsigned ELEMENTS = prur_pkg::ELEMENTS_DEF,
  parameter int unsigned IDX      = 0
) (
  input  wire                          clk,
  input  wire                          rst,
  input  prur_pkg::prur_ctl_t          up_ctl,
  output logic                         up_ready,
  input  wire [prur_pkg::PERM_W-1:0]   up_perm,
  input  wire [prur_pkg::RANK_W-1:0]   up_sum,
  input  wire [prur_pkg::RANK_W-1:0]   up_rem,
  input  wire [ELEMENTS-1:0]           up_free,
  input  wire [prur_pkg::PERM_W-1:0]   up_pout,
  output prur_pkg::prur_ctl_t          dn_ctl,
  input  wire                          dn_ready,
  output logic [prur_pkg::PERM_W-1:0]  dn_perm,
  output logic [prur_pkg::RANK_W-1:0]  dn_sum,
  output logic [prur_pkg::RANK_W-1:0]  dn_rem,
  output logic [ELEMENTS-1:0]          dn_free,
  output logic [prur_pkg::PERM_W-1:0]  dn_pout
);
  import prur_pkg::*;

  localparam int unsigned   CNT_W  = $clog2(ELEMENTS);
  localparam logic [63:0]   WFULL  = fact(IDX);
  localparam logic [RANK_W-1:0] WEIGHT = WFULL[RANK_W-1:0];

  logic                vld;
  logic                mode;
  logic [PERM_W-1:0]   perm;
  logic [RANK_W-1:0]   sum;
  logic [RANK_W-1:0]   rem;
  logic [ELEMENTS-1:0] free;
  logic [PERM_W-1:0]   pout;

  logic [POS_BITS-1:0] vi;
  logic [CNT_W-1:0]    larger;
  logic [CNT_W-1:0]    digit;
  logic [CNT_W-1:0]    above;
  logic [CNT_W-1:0]    val;
  logic [ELEMENTS-1:0] pick;
  logic [RANK_W-1:0]   sub;
  logic [RANK_W-1:0]   sum_next;
  logic [RANK_W-1:0]   rem_next;
  logic [ELEMENTS-1:0] free_next;
  logic [PERM_W-1:0]   pout_next;

  assign up_ready = !vld || dn_ready;

  always_comb begin
    // rank: earlier positions holding a larger value, weighted by IDX!
    vi     = get_pos(up_perm, IDX);
    larger = '0;
    for (int unsigned j = 0; j < IDX; j++) begin
      if (get_pos(up_perm, j) > vi) begin
        larger = larger + CNT_W'(1);
      end
    end
    sum_next = up_sum + RANK_W'(RANK_W'(larger) * WEIGHT);

    // unrank digit: multiples of IDX! that fit in the remainder
    digit = '0;
    sub   = '0;
    for (int unsigned k = 1; k <= IDX; k++) begin
      if (64'(up_rem) >= 64'(k) * WFULL) begin
        digit = CNT_W'(k);
        sub   = RANK_W'(64'(k) * WFULL);
      end
    end
    rem_next = up_rem - sub;

    // digit-th largest free value
    pick  = '0;
    val   = '0;
    above = '0;
    for (int unsigned v = 0; v < ELEMENTS; v++) begin
      above = '0;
      for (int unsigned w = v + 1; w < ELEMENTS; w++) begin
        if (up_free[w]) begin
          above = above + CNT_W'(1);
        end
      end
      if (up_free[v] && above == digit) begin
        pick[v] = 1'b1;
        val     = CNT_W'(v);
      end
    end
    free_next = up_free & ~pick;
    // slots above the field shift out to zero
    pout_next = up_pout | (PERM_W'(val) << (IDX * POS_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      mode <= up_ctl.mode;
      perm <= up_perm;
      sum  <= sum_next;
      rem  <= rem_next;
      free <= free_next;
      pout <= pout_next;
    end
  end

  assign dn_ctl.valid = vld;
  assign dn_ctl.mode  = mode;
  assign dn_perm      = perm;
  assign dn_sum       = sum;
  assign dn_rem       = rem;
  assign dn_free      = free;
  assign dn_pout      = pout;

  a_one_taken : assert property (@(posedge clk) disable iff (rst)
    vld |-> $countones(free) == IDX)
    else $error("free mask did not lose exactly one value");

  a_rem_below : assert property (@(posedge clk) disable iff (rst)
    vld |-> 64'(rem) < WFULL)
    else $error("remainder not below the cell weight");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    vld && !dn_ready |=> vld && $stable(free) && $stable(sum) && $stable(pout))
    else $error("cell lost its item during a stall");

endmodule
`default_nettype wire

FILE: rtl/permutation_rank_unrank_core.sv
// Permutation rank / unrank core (Lehmer code).
//
// Input channel (in_valid / in_ready) carries one item: mode, perm_in and
// rank_in. mode 0 ranks perm_in (4 bits per position, position 0 in the low
// bits) into rank_out; mode 1 unranks rank_in into perm_out. The unused
// result field of each item reads as zero. Coordinates of ELEMENTS! or more
// wrap; ranks wider than 16 bits keep their low 16 bits.
//
// Output channel (out_valid / out_ready) returns exactly one item per input
// item, in order. Two front stages reduce the coordinate mod ELEMENTS!,
// then one cell per position, top position first. Throughput is one item
// per cycle while out_ready is high.
//
// Every stage has its own valid bit and holds its item while the stage
// after it is full and stalled, so when out_ready is low the pipeline keeps
// filling its empty stages and in_ready drops only once all are full.
// Reset (rst, synchronous) empties every stage; payload is not cleared.
`default_nettype none
module permutation_rank_unrank_core #(
  parameter int unsigned ELEMENTS = prur_pkg::ELEMENTS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         mode,
  input  wire [31:0]  perm_in,
  input  wire [15:0]  rank_in,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [15:0] rank_out,
  output logic [31:0] perm_out
);
  import prur_pkg::*;

  // chain taps: index 0 leaves the front, index ELEMENTS is the output
  prur_ctl_t           in_ctl;
  prur_ctl_t           ctl_c   [0:ELEMENTS];
  logic                ready_c [0:ELEMENTS];
  logic [PERM_W-1:0]   perm_c  [0:ELEMENTS];
  logic [RANK_W-1:0]   sum_c   [0:ELEMENTS];
  logic [RANK_W-1:0]   rem_c   [0:ELEMENTS];
  logic [ELEMENTS-1:0] free_c  [0:ELEMENTS];
  logic [PERM_W-1:0]   pout_c  [0:ELEMENTS];

  assign in_ctl.valid = in_valid;
  assign in_ctl.mode  = mode;

  prur_front #(
    .ELEMENTS (ELEMENTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .up_ctl   (in_ctl),
    .up_ready (in_ready),
    .up_perm  (perm_in),
    .up_coord (rank_in),
    .dn_ctl   (ctl_c[0]),
    .dn_ready (ready_c[0]),
    .dn_perm  (perm_c[0]),
    .dn_rem   (rem_c[0])
  );

  // fresh item: no rank yet, all values free, nothing placed
  assign sum_c[0]  = '0;
  assign free_c[0] = '1;
  assign pout_c[0] = '0;

  // cell c handles position ELEMENTS-1-c, so placement runs top down
  for (genvar c = 0; c < ELEMENTS; c++) begin : g_cell
    prur_cell #(
      .ELEMENTS (ELEMENTS),
      .IDX      (ELEMENTS - 1 - c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_ctl   (ctl_c[c]),
      .up_ready (ready_c[c]),
      .up_perm  (perm_c[c]),
      .up_sum   (sum_c[c]),
      .up_rem   (rem_c[c]),
      .up_free  (free_c[c]),
      .up_pout  (pout_c[c]),
      .dn_ctl   (ctl_c[c+1]),
      .dn_ready (ready_c[c+1]),
      .dn_perm  (perm_c[c+1]),
      .dn_sum   (sum_c[c+1]),
      .dn_rem   (rem_c[c+1]),
      .dn_free  (free_c[c+1]),
      .dn_pout  (pout_c[c+1])
    );
  end

  // last cell's registers are the output register
  assign ready_c[ELEMENTS] = out_ready;
  assign out_valid         = ctl_c[ELEMENTS].valid;
  assign rank_out          = ctl_c[ELEMENTS].mode ? '0 : sum_c[ELEMENTS];
  assign perm_out          = ctl_c[ELEMENTS].mode ? pout_c[ELEMENTS] : '0;

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the Lehmer-code rank / unrank core.
// One initial block runs the tests in order. Each test sends items through
// offer_item, which also predicts the result of each accepted item and
// queues it. An independent receiver process drives out_ready, with random
// stalls and requested long hold-offs, and checks every item that comes
// out against the oldest queued prediction.
module tb_top;

  localparam int N           = prur_pkg::ELEMENTS_DEF;
  localparam int SLOTS       = 8;        // 4-bit positions in perm_in/out
  localparam int LATENCY     = N + 2;
  localparam int HOLD_CYCLES = 60;       // long receiver hold-off
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] rank;
    logic [31:0] perm;
  } code_pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = 1'b0;
  logic [31:0] perm_in = '0;
  logic [15:0] rank_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] rank_out;
  logic [31:0] perm_out;

  code_pair_t  pending_codes[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // idle rates in percent, changed per test; 0 means no idling
  int unsigned tx_gap_pct   = 0;
  int unsigned rx_stall_pct = 0;

  // long hold-off requests: written by the tests, served by the receiver
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;

  permutation_rank_unrank_core #(.ELEMENTS(N)) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .perm_in   (perm_in),
    .rank_in   (rank_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rank_out  (rank_out),
    .perm_out  (perm_out)
  );

  always #6 clk = ~clk;

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Position i of a packed permutation; positions past the field read 0.
  function automatic int unsigned nibble_at(logic [31:0] p, int i);
    int unsigned v;
    v = 0;
    if (i < SLOTS) begin
      v = p[i*4 +: 4];
    end
    return v;
  endfunction

  // Sum over positions of (earlier larger values) * i!, low 16 bits kept.
  function automatic logic [15:0] lehmer_rank(logic [31:0] p);
    logic [63:0] sum;
    logic [63:0] weight;
    int unsigned larger;
    int unsigned vi;
    sum    = '0;
    weight = 64'd1;
    for (int i = 1; i < N; i++) begin
      vi     = nibble_at(p, i);
      weight = weight * i;
      larger = 0;
      for (int j = 0; j < i; j++) begin
        if (nibble_at(p, j) > vi) begin
          larger++;
        end
      end
      sum = sum + weight * larger;
    end
    return sum[15:0];
  endfunction

  // Mixed-radix digits, then from the top position down each position
  // takes the digit-th largest value still free. Top digit wraps mod N.
  function automatic logic [31:0] lehmer_unrank(logic [15:0] c);
    int unsigned digit[16];
    bit          taken[16];
    int unsigned coord;
    int unsigned skip;
    bit          placed;
    logic [31:0] result;
    coord  = c;
    result = '0;
    for (int i = 0; i < 16; i++) begin
      taken[i] = 1'b0;
      digit[i] = 0;
    end
    for (int i = 1; i < N; i++) begin
      digit[i] = coord % (i + 1);
      coord    = coord / (i + 1);
    end
    for (int pos = N - 1; pos >= 0; pos--) begin
      skip   = digit[pos];
      placed = 1'b0;
      for (int v = N - 1; v >= 0; v--) begin
        if (!placed && !taken[v]) begin
          if (skip == 0) begin
            taken[v] = 1'b1;
            placed   = 1'b1;
            if (pos < SLOTS) begin
              result[pos*4 +: 4] = v[3:0];
            end
          end else begin
            skip--;
          end
        end
      end
    end
    return result;
  endfunction

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // No gap unless a pct-percent draw hits; then mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap(int unsigned pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r >= pct) begin
      return 0;
    end
    if ($urandom_range(9) < 8) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 8);
  endfunction

  // Offers one item and waits for it to be accepted. in_valid stays high
  // when the next item follows without a gap.
  task automatic offer_item(logic m, logic [31:0] p, logic [15:0] r);
    int unsigned gap;
    code_pair_t  want;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    perm_in  <= p;
    rank_in  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // the unused result field of an item reads as zero
    want.rank = m ? 16'd0 : lehmer_rank(p);
    want.perm = m ? lehmer_unrank(r) : 32'd0;
    pending_codes.insert(pending_codes.size(), want);
  endtask

  // Random shuffle of 0..N-1 packed 4 bits per position.
  function automatic logic [31:0] shuffled_perm();
    int unsigned vals[16];
    int unsigned k;
    int unsigned t;
    logic [31:0] p;
    p = '0;
    for (int i = 0; i < N; i++) begin
      vals[i] = i;
    end
    for (int i = N - 1; i > 0; i--) begin
      k       = $urandom_range(i);
      t       = vals[i];
      vals[i] = vals[k];
      vals[k] = t;
    end
    for (int i = 0; i < N && i < SLOTS; i++) begin
      p[i*4 +: 4] = vals[i][3:0];
    end
    return p;
  endfunction

  // Mostly in-range coordinates; some that wrap past N!.
  function automatic logic [15:0] pick_coord();
    if ($urandom_range(9) < 7) begin
      return 16'($urandom_range(40319));
    end
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;

  always @(posedge clk) begin
    code_pair_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      // out_valid / out_ready seen here are the pre-edge values
      if (out_valid && out_ready) begin
        if (pending_codes.size() == 0) begin
          $display("%0t: unexpected item, rank_out %0d perm_out %h",
                   $time, rank_out, perm_out);
          error_count++;
        end else begin
          want = pending_codes.pop_front();
          if (rank_out !== want.rank) begin
            $display("%0t: rank_out mismatch, expected %0d, got %0d",
                     $time, want.rank, rank_out);
            error_count++;
          end
          if (perm_out !== want.perm) begin
            $display("%0t: perm_out mismatch, expected %h, got %h",
                     $time, want.perm, perm_out);
            error_count++;
          end
        end
      end
      // a requested hold-off wins over the random stalls
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        stall_left = pick_gap(100) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Corner permutations, including inputs that are not permutations.
  task automatic test_rank_corners();
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    offer_item(1'b0, 32'h7654_3210, 16'h0000);  // identity, rank 0
    offer_item(1'b0, 32'h0123_4567, 16'hFFFF);  // reversed, top rank
    offer_item(1'b0, 32'h7654_3201, 16'h0000);  // one swap at the bottom
    offer_item(1'b0, 32'h6754_3210, 16'h0000);  // one swap at the top
    offer_item(1'b0, 32'h0000_0000, 16'h0000);  // all repeated
    offer_item(1'b0, 32'h3333_3333, 16'h0000);
    offer_item(1'b0, 32'hFFFF_FFFF, 16'hFFFF);  // values above range
    offer_item(1'b0, 32'h89AB_CDEF, 16'h0000);
    offer_item(1'b0, 32'hA5A5_A5A5, 16'h5A5A);
    offer_item(1'b0, 32'h5A5A_5A5A, 16'hA5A5);
    offer_item(1'b0, 32'h0F0F_0F0F, 16'h0000);
  endtask

  // Corner coordinates, including ones that wrap past N!.
  task automatic test_unrank_corners();
    offer_item(1'b1, 32'h0000_0000, 16'd0);
    offer_item(1'b1, 32'hFFFF_FFFF, 16'd1);
    offer_item(1'b1, 32'h0000_0000, 16'd40319);
    offer_item(1'b1, 32'h0000_0000, 16'd40320);  // first wrapping value
    offer_item(1'b1, 32'h0000_0000, 16'hFFFF);
    offer_item(1'b1, 32'h0000_0000, 16'h8000);
    offer_item(1'b1, 32'h1234_5678, 16'h5555);
    offer_item(1'b1, 32'h0000_0000, 16'hAAAA);
    offer_item(1'b1, 32'h0000_0000, 16'd5039);   // 7! - 1
    offer_item(1'b1, 32'h0000_0000, 16'd5040);   // 7!
  endtask

  // Well-formed permutations and in-range coordinates, both directions.
  task automatic test_valid_codes(int unsigned count);
    tx_gap_pct   = 25;
    rx_stall_pct = 25;
    repeat (count) begin
      if ($urandom_range(1) == 0) begin
        offer_item(1'b0, shuffled_perm(), 16'($urandom));
      end else begin
        offer_item(1'b1, 32'($urandom), 16'($urandom_range(40319)));
      end
    end
  endtask

  // Mix of modes; mostly well-formed, the rest raw bit patterns.
  task automatic test_random_mix(int unsigned count);
    logic [31:0] p;
    tx_gap_pct   = 40;
    rx_stall_pct = 40;
    repeat (count) begin
      p = ($urandom_range(9) < 7) ? shuffled_perm() : 32'($urandom);
      offer_item(1'($urandom), p, pick_coord());
    end
  endtask

  // Receiver holds off long enough for the pipeline to fill while the
  // sender keeps offering back to back.
  task automatic test_back_pressure(int unsigned count);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_requests++;
    repeat (count) begin
      offer_item(1'($urandom), shuffled_perm(), pick_coord());
    end
  endtask

  // Full rate on both sides.
  task automatic test_full_rate(int unsigned count);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (count) begin
      offer_item(1'($urandom), 32'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rank_corners();
    test_unrank_corners();
    test_valid_codes(320);
    test_back_pressure(40);
    test_random_mix(510);
    test_full_rate(60);

    in_valid     <= 1'b0;
    rx_stall_pct = 20;
    while (pending_codes.size() != 0) @(posedge clk);
    // give any stray extra item time to show up
    repeat (LATENCY + 10) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
